### src/csv_column_field_extractor_macros.svh
// Assertion macros shared by the CSV column field extractor.
`ifndef CSV_COLUMN_FIELD_EXTRACTOR_MACROS_SVH
`define CSV_COLUMN_FIELD_EXTRACTOR_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define CCFE_CHECK(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Checks that a consequent holds whenever its antecedent does.
`define CCFE_IMPLIES(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

### src/ccfe_pkg.sv
// Package with types, character codes and helpers for the CSV column field extractor.
`timescale 1ns / 1ps

package ccfe_pkg;

	// Default width of the running byte position counter.
	localparam int unsigned POSITION_WIDTH_DEF = 32;
	localparam int unsigned COL_W = 10;
	localparam int unsigned POS_OUT_W = 32;

	// Characters with a meaning to the parser.
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_ESC   = 8'h5C;

	// Parser modes.
	typedef enum logic [2:0] {
		M_SKIP,
		M_SKIP_ESC,
		M_SKIP_QUOTE,
		M_SKIP_AFTERQ,
		M_FIELD,
		M_FIELD_ESC,
		M_FIELD_QUOTE,
		M_DONE
	} ccfe_mode_t;

	// One result as it leaves the block.
	typedef struct packed {
		logic [7:0]           out_char;
		logic [POS_OUT_W-1:0] position;
		logic                 is_terminator;
		logic                 final_res;
	} ccfe_res_t;

	// All results caused by one input byte.
	typedef struct packed {
		logic [1:0] count;
		ccfe_res_t  res0;
		ccfe_res_t  res1;
	} ccfe_batch_t;

	// ASCII upper case letters become lower case, all else passes.
	function automatic logic [7:0] to_lower(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= 8'h41 && c <= 8'h5A) begin
			r = c + 8'h20;
		end
		return r;
	endfunction

endpackage

### src/ccfe_parser.sv
// Per-byte CSV parser: parse state, column register and result assembly.
`timescale 1ns / 1ps

module ccfe_parser import ccfe_pkg::*; #(
	parameter int unsigned POSITION_WIDTH = POSITION_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [COL_W-1:0] cfg_data,
	input  logic [7:0]       line_byte,
	input  logic             line_end,
	input  logic             advance,
	output ccfe_batch_t      batch
);

	logic [POSITION_WIDTH-1:0] byte_position_q;
	logic [COL_W-1:0]          column_select_q;
	logic [COL_W-1:0]          columns_passed_q;
	logic                      at_field_start_q;
	ccfe_mode_t                mode_q;

	ccfe_mode_t                mode_n;
	logic [COL_W-1:0]          cols_n;
	logic [COL_W-1:0]          cols_inc;
	logic                      afs_n;
	logic                      e_valid;
	logic                      e_term;
	logic                      lt_valid;
	logic [POSITION_WIDTH-1:0] pos_next;
	ccfe_mode_t                start_mode;
	ccfe_res_t                 e_res;
	ccfe_res_t                 lt_res;

	assign cols_inc   = columns_passed_q + COL_W'(1);
	assign pos_next   = byte_position_q + POSITION_WIDTH'(1);
	assign start_mode = (column_select_q == '0) ? M_FIELD : M_SKIP;

	// Next parse state and the in-line result for the byte at hand.
	always_comb begin
		mode_n  = mode_q;
		cols_n  = columns_passed_q;
		afs_n   = at_field_start_q;
		e_valid = 1'b0;
		e_term  = 1'b0;
		case (mode_q)
			M_SKIP: begin
				if (line_byte == CH_NUL) begin
					e_valid = 1'b1;
					e_term  = 1'b1;
					mode_n  = M_DONE;
				end else if (line_byte == CH_ESC) begin
					afs_n  = 1'b0;
					mode_n = M_SKIP_ESC;
				end else if (line_byte == CH_QUOTE && at_field_start_q) begin
					afs_n  = 1'b0;
					mode_n = M_SKIP_QUOTE;
				end else if (line_byte == CH_COMMA) begin
					cols_n = cols_inc;
					afs_n  = 1'b1;
					mode_n = (cols_inc == column_select_q) ? M_FIELD : M_SKIP;
				end else begin
					afs_n = 1'b0;
				end
			end
			M_SKIP_ESC: begin
				if (line_byte == CH_NUL) begin
					e_valid = 1'b1;
					e_term  = 1'b1;
					mode_n  = M_DONE;
				end else begin
					mode_n = M_SKIP;
				end
			end
			M_SKIP_QUOTE: begin
				if (line_byte == CH_QUOTE) begin
					mode_n = M_SKIP_AFTERQ;
				end else if (line_byte == CH_NUL) begin
					mode_n = M_DONE;
				end
			end
			M_SKIP_AFTERQ: begin
				if (line_byte == CH_NUL) begin
					e_valid = 1'b1;
					e_term  = 1'b1;
					mode_n  = M_DONE;
				end else if (line_byte == CH_COMMA) begin
					cols_n = cols_inc;
					afs_n  = 1'b1;
					mode_n = (cols_inc == column_select_q) ? M_FIELD : M_SKIP;
				end else begin
					afs_n  = 1'b0;
					mode_n = M_SKIP;
				end
			end
			M_FIELD: begin
				if (line_byte == CH_NUL || line_byte == CH_NL || line_byte == CH_COMMA) begin
					e_valid = 1'b1;
					e_term  = 1'b1;
					mode_n  = M_DONE;
				end else if (line_byte == CH_ESC) begin
					afs_n  = 1'b0;
					mode_n = M_FIELD_ESC;
				end else if (line_byte == CH_QUOTE && at_field_start_q) begin
					afs_n  = 1'b0;
					mode_n = M_FIELD_QUOTE;
				end else begin
					e_valid = 1'b1;
					afs_n   = 1'b0;
				end
			end
			M_FIELD_ESC: begin
				e_valid = 1'b1;
				if (line_byte == CH_NUL) begin
					e_term = 1'b1;
					mode_n = M_DONE;
				end else begin
					mode_n = M_FIELD;
				end
			end
			M_FIELD_QUOTE: begin
				if (line_byte == CH_QUOTE) begin
					mode_n = M_FIELD;
				end else if (line_byte == CH_NUL) begin
					mode_n = M_DONE;
				end else begin
					e_valid = 1'b1;
				end
			end
			default: begin
			end
		endcase

		// A line end closes the field unless it stopped or a quote is open.
		lt_valid = line_end && mode_n != M_DONE && mode_n != M_SKIP_QUOTE &&
			mode_n != M_FIELD_QUOTE;
		if (line_end) begin
			cols_n = '0;
			afs_n  = 1'b1;
			mode_n = start_mode;
		end
	end

	// Results are packed in order; the last one carries the final flag.
	always_comb begin
		e_res.out_char      = e_term ? CH_NL : to_lower(line_byte);
		e_res.position      = POS_OUT_W'(byte_position_q);
		e_res.is_terminator = e_term;
		e_res.final_res     = !lt_valid;
		lt_res.out_char      = CH_NL;
		lt_res.position      = POS_OUT_W'(pos_next);
		lt_res.is_terminator = 1'b1;
		lt_res.final_res     = 1'b1;
		batch.count = {1'b0, e_valid} + {1'b0, lt_valid};
		batch.res0  = e_valid ? e_res : lt_res;
		batch.res1  = lt_res;
	end

	// Parse state steps per consumed byte; user keeps register writes to idle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_position_q  <= '0;
			column_select_q  <= '0;
			columns_passed_q <= '0;
			at_field_start_q <= 1'b1;
			mode_q           <= M_FIELD;
		end else begin
			if (cfg_we) begin
				column_select_q <= cfg_data;
			end
			if (advance) begin
				byte_position_q  <= pos_next;
				columns_passed_q <= cols_n;
				at_field_start_q <= afs_n;
				mode_q           <= mode_n;
			end else if (cfg_we && (mode_q == M_SKIP || mode_q == M_FIELD) &&
				columns_passed_q == '0 && at_field_start_q) begin
				mode_q <= (cfg_data == '0) ? M_FIELD : M_SKIP;
			end
		end
	end

endmodule

### src/ccfe_out_buf.sv
// Two-entry result register that hands one result per transfer downstream.
`timescale 1ns / 1ps

module ccfe_out_buf import ccfe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  ccfe_batch_t batch,
	input  logic        load,
	output logic        can_load,
	output logic        out_valid,
	input  logic        out_ready,
	output ccfe_res_t   out_res
);

	logic [1:0] cnt_q;
	ccfe_res_t  slot0_q;
	ccfe_res_t  slot1_q;
	logic       pop;

	assign out_valid = cnt_q != 2'd0;
	assign out_res   = slot0_q;
	assign pop       = out_valid && out_ready;
	// A new batch fits once the buffer drains in this cycle.
	assign can_load  = cnt_q == 2'd0 || (cnt_q == 2'd1 && out_ready);

	// Fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= batch.count;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// Result slots; the second moves up when the first is taken.
	always_ff @(posedge clk) begin
		if (load) begin
			slot0_q <= batch.res0;
			slot1_q <= batch.res1;
		end else if (pop) begin
			slot0_q <= slot1_q;
		end
	end

endmodule

### src/csv_column_field_extractor.sv
// CSV column field extractor: the input register stage, parser and output buffer.
//
// Usage: CSV text enters on the s_axis channel, one byte per transfer, with
// s_axis_tlast set on the last byte of each line. cfg_we/cfg_data write the
// zero-based column to extract; write it only while the block is idle.
// For each line the selected field leaves on m_axis, one byte per transfer,
// lowercased with its stream byte offset, followed by a newline terminator
// flagged on m_axis_tuser. m_axis_tlast marks the last result caused by an
// input byte; a byte can cause zero, one or two results.
// A byte's first result passes from the input register through the output
// buffer before it is valid; a low m_axis_tready can hold it in between.
// Throughput: one byte per cycle while each byte causes at most one result
// and m_axis_tready stays high; a byte with two results holds the input
// stage until the single-result output port has taken the first of them.
// Reset clears the byte position, selects column zero and empties both
// stages. When m_axis_tready is low, results wait in a two-entry buffer and
// s_axis_tready drops once the input register holds a byte it cannot retire.
`timescale 1ns / 1ps
`include "csv_column_field_extractor_macros.svh"

module csv_column_field_extractor import ccfe_pkg::*; #(
	parameter int unsigned POSITION_WIDTH = POSITION_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [COL_W-1:0] cfg_data,       // column_select
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [7:0]       s_axis_tdata,   // [7:0] line_byte
	input  logic             s_axis_tlast,   // line_end
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [39:0]      m_axis_tdata,   // [7:0] out_char, [39:8] position
	output logic             m_axis_tlast,   // final_res
	output logic             m_axis_tuser    // is_terminator
);

	logic        s1_valid_q;
	logic [7:0]  line_byte_s1;
	logic        line_end_s1;
	logic        consume;
	logic        can_load;
	ccfe_batch_t batch;
	ccfe_res_t   out_res;

	// A held byte retires when it has no results or the buffer can take them.
	assign consume       = s1_valid_q && (batch.count == 2'd0 || can_load);
	assign s_axis_tready = !s1_valid_q || consume;

	// Input register stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			s1_valid_q <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			line_byte_s1 <= s_axis_tdata;
			line_end_s1  <= s_axis_tlast;
		end
	end

	ccfe_parser #(
		.POSITION_WIDTH(POSITION_WIDTH)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.line_byte (line_byte_s1),
		.line_end  (line_end_s1),
		.advance   (consume),
		.batch     (batch)
	);

	ccfe_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.batch     (batch),
		.load      (consume && batch.count != 2'd0),
		.can_load  (can_load),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res)
	);

	// Output port packing.
	assign m_axis_tdata = {out_res.position, out_res.out_char};
	assign m_axis_tlast = out_res.final_res;
	assign m_axis_tuser = out_res.is_terminator;

	// A byte with results only waits while the output side is occupied.
	`CCFE_IMPLIES(a_stall_only_when_full, s1_valid_q && batch.count != 2'd0 && !consume, m_axis_tvalid, "input stage stalled with an empty output buffer")
	// No byte causes more than two results.
	`CCFE_IMPLIES(a_batch_bounded, s1_valid_q, batch.count != 2'd3, "more than two results for one byte")
	// Terminators always carry the newline code.
	`CCFE_IMPLIES(a_term_is_newline, m_axis_tvalid && m_axis_tuser, m_axis_tdata[7:0] == CH_NL, "terminator without newline code")

endmodule
